// File: rtl/core/button_gesture_mode_menu_defines.svh
// assertion macros shared by the gesture menu checker
`ifndef BUTTON_GESTURE_MODE_MENU_DEFINES_SVH
`define BUTTON_GESTURE_MODE_MENU_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BGMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BGMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

// File: rtl/core/bgmm_pkg.sv
// types, codes and reset values for the button gesture mode menu
`default_nettype none

package bgmm_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    FUNC_PRESS   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_TICK    = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    EV_NONE           = 3'd0,
    EV_SINGLE         = 3'd1,
    EV_MENU_OPEN      = 3'd2,
    EV_MENU_MOVE      = 3'd3,
    EV_MENU_TIMEOUT   = 3'd4,
    EV_CONFIRM_SAME   = 3'd5,
    EV_CONFIRM_SWITCH = 3'd6
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DOUBLE_CLICK_WINDOW = 3'd0,
    CFG_SHORT_CLICK         = 3'd1,
    CFG_ENTER_MENU          = 3'd2,
    CFG_CONFIRM             = 3'd3,
    CFG_MENU_TIMEOUT        = 3'd4,
    CFG_RUNNING_MODE        = 3'd5
  } cfg_idx_e;

  localparam logic [CfgW-1:0] DoubleClickWindowRst = 16'd300;
  localparam logic [CfgW-1:0] ShortClickRst        = 16'd500;
  localparam logic [CfgW-1:0] EnterMenuRst         = 16'd2000;
  localparam logic [CfgW-1:0] ConfirmRst           = 16'd1000;
  localparam logic [CfgW-1:0] MenuTimeoutRst       = 16'd5000;

  typedef struct packed {
    logic button_down;
    logic click_pending;
    logic menu_open;
    logic awaiting_release;
    logic confirm_done;
    logic chosen_mode;
  } gest_state_t;

  function automatic event_e confirm_code(input logic sel, input logic running);
    return (sel == running) ? EV_CONFIRM_SAME : EV_CONFIRM_SWITCH;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/button_gesture_mode_menu.sv
// One-button gesture recognizer with a two-entry mode menu. Each accepted
// transaction (press, release or tick with a 32-bit ms timestamp) gives exactly
// one result: an event code and a mode. Single clicks are reported on a tick once
// the double-click window has run out; a second press inside the window confirms
// the other mode; a long hold opens the menu, short clicks move the selection, a
// further hold confirms and inactivity cancels. The block takes one transaction
// per clock while the result is not stalled: an input register feeds one stage
// of compare/update logic into a result register, and the next transaction is
// taken while a result waits. Configuration writes are accepted in any cycle
// but must only be issued while the block is idle.
`default_nettype none

module button_gesture_mode_menu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         func_i,
  input  logic [bgmm_pkg::TimeW-1:0]         now_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         event_res_o,
  output logic                               mode_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bgmm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [bgmm_pkg::CfgW-1:0]          cfg_data_i
);

  // configuration registers
  logic [bgmm_pkg::CfgW-1:0] dbl_win_q, short_q, enter_q, confirm_q, timeout_q;
  logic                      running_q;

  // input register
  logic                       s1_valid_q;
  logic [1:0]                 s1_func_q;
  logic [bgmm_pkg::TimeW-1:0] s1_now_q;

  // gesture state
  bgmm_pkg::gest_state_t      st_q, st_d;
  logic [bgmm_pkg::TimeW-1:0] press_q, press_d;
  logic [bgmm_pkg::TimeW-1:0] rel_q, rel_d;
  logic [bgmm_pkg::TimeW-1:0] deadline_q, deadline_d;

  // result register
  logic             out_valid_q;
  bgmm_pkg::event_e code_q, code_d;
  logic             mode_q, mode_d;

  logic s1_move;
  logic in_accept;

  logic [bgmm_pkg::TimeW-1:0] since_press, since_rel, since_deadline, new_deadline;
  logic                       dbl_hit, single_due;

  assign cfg_ready_o = 1'b1;
  assign s1_move     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_move;
  assign in_accept   = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign event_res_o = code_q;
  assign mode_o      = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_win_q <= bgmm_pkg::DoubleClickWindowRst;
      short_q   <= bgmm_pkg::ShortClickRst;
      enter_q   <= bgmm_pkg::EnterMenuRst;
      confirm_q <= bgmm_pkg::ConfirmRst;
      timeout_q <= bgmm_pkg::MenuTimeoutRst;
      running_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bgmm_pkg::CFG_DOUBLE_CLICK_WINDOW: dbl_win_q <= cfg_data_i;
        bgmm_pkg::CFG_SHORT_CLICK:         short_q   <= cfg_data_i;
        bgmm_pkg::CFG_ENTER_MENU:          enter_q   <= cfg_data_i;
        bgmm_pkg::CFG_CONFIRM:             confirm_q <= cfg_data_i;
        bgmm_pkg::CFG_MENU_TIMEOUT:        timeout_q <= cfg_data_i;
        bgmm_pkg::CFG_RUNNING_MODE:        running_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // modular time differences
  assign since_press    = s1_now_q - press_q;
  assign since_rel      = s1_now_q - rel_q;
  assign since_deadline = s1_now_q - deadline_q;
  assign new_deadline   = s1_now_q + {{(bgmm_pkg::TimeW-bgmm_pkg::CfgW){1'b0}}, timeout_q};

  assign dbl_hit = !st_q.menu_open && st_q.click_pending &&
                   (since_rel <= {{(bgmm_pkg::TimeW-bgmm_pkg::CfgW){1'b0}}, dbl_win_q});
  assign single_due = st_q.click_pending && !st_q.button_down &&
                      (since_rel >= {{(bgmm_pkg::TimeW-bgmm_pkg::CfgW){1'b0}}, dbl_win_q});

  always_comb begin
    st_d       = st_q;
    press_d    = press_q;
    rel_d      = rel_q;
    deadline_d = deadline_q;
    code_d     = bgmm_pkg::EV_NONE;
    mode_d     = 1'b0;
    case (s1_func_q)
      bgmm_pkg::FUNC_PRESS: begin
        if (!st_q.button_down) begin
          // a pending click is consumed by any press outside the menu
          st_d.click_pending = st_q.click_pending && st_q.menu_open;
          st_d.button_down   = 1'b1;
          st_d.confirm_done  = 1'b0;
          press_d            = s1_now_q;
          if (dbl_hit) begin
            mode_d = !running_q;
            code_d = bgmm_pkg::confirm_code(!running_q, running_q);
          end
        end
      end
      bgmm_pkg::FUNC_RELEASE: begin
        if (st_q.button_down) begin
          st_d.button_down = 1'b0;
          if (st_q.menu_open) begin
            if (st_q.awaiting_release) begin
              st_d.awaiting_release = 1'b0;
              deadline_d            = new_deadline;
            end else if (!st_q.confirm_done &&
                         since_press < {{(bgmm_pkg::TimeW-bgmm_pkg::CfgW){1'b0}}, short_q}) begin
              st_d.chosen_mode = !st_q.chosen_mode;
              deadline_d       = new_deadline;
              code_d           = bgmm_pkg::EV_MENU_MOVE;
              mode_d           = !st_q.chosen_mode;
            end
          end else if (since_press < {{(bgmm_pkg::TimeW-bgmm_pkg::CfgW){1'b0}}, short_q}) begin
            st_d.click_pending = 1'b1;
            rel_d              = s1_now_q;
          end else begin
            st_d.click_pending = 1'b0;
          end
        end
      end
      bgmm_pkg::FUNC_TICK: begin
        if (single_due) begin
          st_d.click_pending = 1'b0;
        end
        if (!st_q.menu_open && st_q.button_down &&
            since_press >= {{(bgmm_pkg::TimeW-bgmm_pkg::CfgW){1'b0}}, enter_q}) begin
          st_d.click_pending    = 1'b0;
          st_d.menu_open        = 1'b1;
          st_d.awaiting_release = 1'b1;
          st_d.chosen_mode      = running_q;
          deadline_d            = new_deadline;
          code_d                = bgmm_pkg::EV_MENU_OPEN;
          mode_d                = running_q;
        end else if (st_q.menu_open && !st_q.awaiting_release && st_q.button_down &&
                     !st_q.confirm_done &&
                     since_press >= {{(bgmm_pkg::TimeW-bgmm_pkg::CfgW){1'b0}}, confirm_q}) begin
          st_d.confirm_done = 1'b1;
          st_d.menu_open    = 1'b0;
          mode_d            = st_q.chosen_mode;
          code_d            = bgmm_pkg::confirm_code(st_q.chosen_mode, running_q);
        end else if (st_q.menu_open && !since_deadline[bgmm_pkg::TimeW-1]) begin
          // deadline reached when the modular difference is non-negative
          st_d.menu_open        = 1'b0;
          st_d.awaiting_release = 1'b0;
          code_d                = bgmm_pkg::EV_MENU_TIMEOUT;
        end else if (single_due) begin
          code_d = bgmm_pkg::EV_SINGLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= func_i;
      s1_now_q  <= now_ms_i;
    end
    if (s1_move) begin
      press_q    <= press_d;
      rel_q      <= rel_d;
      deadline_q <= deadline_d;
      code_q     <= code_d;
      mode_q     <= mode_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bgmm_checker.sv
// port-level checks for the button gesture mode menu, bound to the top level
`default_nettype none

`include "button_gesture_mode_menu_defines.svh"

module bgmm_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [2:0]                   event_res_o,
  input wire logic                         mode_o
);

  // a stalled result holds its payload
  `BGMM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(event_res_o) && $stable(mode_o), "stalled result changed")

  // codes without a mode report mode 0
  `BGMM_ASSERT_NOW(a_mode_zero,
    out_valid_o && (event_res_o == bgmm_pkg::EV_NONE || event_res_o == bgmm_pkg::EV_SINGLE ||
    event_res_o == bgmm_pkg::EV_MENU_TIMEOUT), !mode_o, "mode set on a code without mode")

  // every accepted transaction has a result showing once it has been registered
  `BGMM_ASSERT_NOW(a_latency, in_valid_i && in_ready_o, ##2 out_valid_o,
    "no result two cycles after a transaction")

  // with the result register empty the input side never stalls
  `BGMM_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o,
    "input stalled with empty result register")

endmodule

bind button_gesture_mode_menu bgmm_checker u_bgmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .event_res_o (event_res_o),
  .mode_o      (mode_o)
);

`default_nettype wire

// File: tb/tb_button_gesture_mode_menu.sv
// self-checking testbench for the button gesture mode menu block
`default_nettype none

module tb_button_gesture_mode_menu;
  timeunit 1ns;
  timeprecision 1ps;

  import bgmm_pkg::*;

  localparam logic [1:0]         FuncUnknown  = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;
  localparam int SettleCycles = 6;
  localparam int DrainLimit   = 5000;
  localparam int RxHoldCycles = 80;
  localparam int PhaseItems   = 185;

  typedef struct packed {
    event_e code;
    logic   mode;
  } gesture_res_t;

  typedef struct packed {
    logic [1:0]  fn;
    logic [31:0] now;
    logic        typed;
    event_e      code;
    logic        mode;
  } dir_row_t;

  // reset settings: window 300, short 500, enter 2000, confirm 1000, timeout 5000
  localparam int DirCount = 25;
  localparam dir_row_t DirRows [DirCount] = '{
    '{FUNC_TICK,    32'd0,          1'b1, EV_NONE,           1'b0},
    '{FUNC_RELEASE, 32'd10,         1'b1, EV_NONE,           1'b0},
    '{FuncUnknown,  32'hFFFF_FFFF,  1'b1, EV_NONE,           1'b0},
    '{FUNC_PRESS,   32'd100,        1'b1, EV_NONE,           1'b0},
    '{FUNC_PRESS,   32'd150,        1'b1, EV_NONE,           1'b0},
    '{FUNC_RELEASE, 32'd200,        1'b0, EV_NONE,           1'b0},
    '{FUNC_TICK,    32'd499,        1'b0, EV_NONE,           1'b0},
    '{FUNC_TICK,    32'd500,        1'b1, EV_SINGLE,         1'b0},
    '{FUNC_PRESS,   32'd1000,       1'b0, EV_NONE,           1'b0},
    '{FUNC_RELEASE, 32'd1100,       1'b0, EV_NONE,           1'b0},
    '{FUNC_PRESS,   32'd1400,       1'b1, EV_CONFIRM_SWITCH, 1'b1},
    '{FUNC_RELEASE, 32'd1450,       1'b0, EV_NONE,           1'b0},
    '{FUNC_PRESS,   32'd2000,       1'b0, EV_NONE,           1'b0},
    '{FUNC_TICK,    32'd4000,       1'b0, EV_NONE,           1'b0},
    '{FUNC_RELEASE, 32'd4100,       1'b0, EV_NONE,           1'b0},
    '{FUNC_PRESS,   32'd4200,       1'b0, EV_NONE,           1'b0},
    '{FUNC_RELEASE, 32'd4300,       1'b0, EV_NONE,           1'b0},
    '{FUNC_PRESS,   32'd4400,       1'b0, EV_NONE,           1'b0},
    '{FUNC_TICK,    32'd5400,       1'b0, EV_NONE,           1'b0},
    '{FUNC_RELEASE, 32'd5500,       1'b0, EV_NONE,           1'b0},
    // hold across the timestamp wrap, then let the menu expire exactly on its deadline
    '{FUNC_PRESS,   32'hFFFF_F000,  1'b1, EV_NONE,           1'b0},
    '{FUNC_TICK,    32'h0000_07D0,  1'b1, EV_MENU_OPEN,      1'b0},
    '{FUNC_TICK,    32'd6999,       1'b1, EV_NONE,           1'b0},
    '{FUNC_TICK,    32'd7000,       1'b1, EV_MENU_TIMEOUT,   1'b0},
    '{FUNC_RELEASE, 32'd7100,       1'b1, EV_NONE,           1'b0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         func_i;
  logic [TimeW-1:0]   now_ms_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         event_res_o;
  logic               mode_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;

  // register shadow
  logic [15:0] win_ms          = DoubleClickWindowRst;
  logic [15:0] short_ms        = ShortClickRst;
  logic [15:0] enter_ms        = EnterMenuRst;
  logic [15:0] confirm_hold_ms = ConfirmRst;
  logic [15:0] timeout_ms      = MenuTimeoutRst;
  logic        run_mode        = 1'b0;

  // gesture state
  logic        btn_down     = 1'b0;
  logic        click_wait   = 1'b0;
  logic        menu_on      = 1'b0;
  logic        wait_release = 1'b0;
  logic        confirmed    = 1'b0;
  logic        sel_mode     = 1'b0;
  logic [31:0] press_ms     = '0;
  logic [31:0] release_ms   = '0;
  logic [31:0] deadline_ms  = '0;

  gesture_res_t gesture_q[$];
  int mismatch_cnt = 0;
  int events_sent  = 0;
  int results_seen = 0;
  int code_seen [0:7];
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int rx_hold_left = 0;
  logic [31:0] t_ms;

  button_gesture_mode_menu dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_res_o (event_res_o),
    .mode_o      (mode_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic gesture_res_t predict_gesture(input logic [1:0] fn, input logic [31:0] now);
    gesture_res_t r;
    logic        dbl;
    logic        single;
    logic [31:0] held;
    logic [31:0] since;
    r.code = EV_NONE;
    r.mode = 1'b0;
    dbl    = 1'b0;
    single = 1'b0;
    case (fn)
      FUNC_PRESS: begin
        if (!btn_down) begin
          if (!menu_on && click_wait) begin
            click_wait = 1'b0;
            since = now - release_ms;
            dbl = (since <= 32'(win_ms));
          end
          btn_down  = 1'b1;
          confirmed = 1'b0;
          press_ms  = now;
          if (dbl) begin
            r.mode = ~run_mode;
            r.code = (r.mode == run_mode) ? EV_CONFIRM_SAME : EV_CONFIRM_SWITCH;
          end
        end
      end
      FUNC_RELEASE: begin
        if (btn_down) begin
          held = now - press_ms;
          btn_down = 1'b0;
          if (menu_on) begin
            if (wait_release) begin
              wait_release = 1'b0;
              deadline_ms  = now + 32'(timeout_ms);
            end else if (!confirmed && held < 32'(short_ms)) begin
              sel_mode    = ~sel_mode;
              deadline_ms = now + 32'(timeout_ms);
              r.code = EV_MENU_MOVE;
              r.mode = sel_mode;
            end
          end else if (held < 32'(short_ms)) begin
            click_wait = 1'b1;
            release_ms = now;
          end else begin
            click_wait = 1'b0;
          end
        end
      end
      FUNC_TICK: begin
        if (click_wait && !btn_down && (now - release_ms) >= 32'(win_ms)) begin
          click_wait = 1'b0;
          single = 1'b1;
        end
        since = now - deadline_ms;
        if (!menu_on && btn_down && (now - press_ms) >= 32'(enter_ms)) begin
          click_wait   = 1'b0;
          menu_on      = 1'b1;
          wait_release = 1'b1;
          sel_mode     = run_mode;
          deadline_ms  = now + 32'(timeout_ms);
          r.code = EV_MENU_OPEN;
          r.mode = sel_mode;
        end else if (menu_on && !wait_release && btn_down && !confirmed &&
                     (now - press_ms) >= 32'(confirm_hold_ms)) begin
          confirmed = 1'b1;
          menu_on   = 1'b0;
          r.mode = sel_mode;
          r.code = (sel_mode == run_mode) ? EV_CONFIRM_SAME : EV_CONFIRM_SWITCH;
        end else if (menu_on && !since[31]) begin
          menu_on      = 1'b0;
          wait_release = 1'b0;
          r.code = EV_MENU_TIMEOUT;
        end else if (single) begin
          r.code = EV_SINGLE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // duration around a threshold: just below, on, just above, or anywhere
  function automatic logic [31:0] near_ms(input logic [15:0] th);
    int unsigned t;
    t = th;
    case ($urandom_range(5))
      0: return (t == 0) ? 32'd0 : t - 1;
      1: return t;
      2: return t + 1;
      3: return $urandom_range(t);
      default: return t + $urandom_range(t + 50);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_event(input logic [1:0] fn, input logic [31:0] now, input logic typed,
                            input event_e want_code, input logic want_mode);
    gesture_res_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    now_ms_i   <= now;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_gesture(fn, now);
    if (typed) begin
      r.code = want_code;
      r.mode = want_mode;
    end
    gesture_q.push_back(r);
    events_sent++;
  endtask

  task automatic send_ev(input logic [1:0] fn, input logic [31:0] now);
    send_event(fn, now, 1'b0, EV_NONE, 1'b0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DOUBLE_CLICK_WINDOW: win_ms          = val;
      CFG_SHORT_CLICK:         short_ms        = val;
      CFG_ENTER_MENU:          enter_ms        = val;
      CFG_CONFIRM:             confirm_hold_ms = val;
      CFG_MENU_TIMEOUT:        timeout_ms      = val;
      CFG_RUNNING_MODE:        run_mode        = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] win, input logic [15:0] shrt,
                               input logic [15:0] enter, input logic [15:0] conf,
                               input logic [15:0] tmo, input logic run);
    write_reg(CFG_DOUBLE_CLICK_WINDOW, win);
    write_reg(CFG_SHORT_CLICK, shrt);
    write_reg(CFG_ENTER_MENU, enter);
    write_reg(CFG_CONFIRM, conf);
    write_reg(CFG_MENU_TIMEOUT, tmo);
    write_reg(CFG_RUNNING_MODE, {15'd0, run});
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (gesture_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (gesture_q.size() != 0) begin
      report_mismatch("results never delivered, count", 0, gesture_q.size());
      gesture_q.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly well-formed gestures with random timing, some noise mixed in
  task automatic run_gestures(input int goal);
    int k;
    while (events_sent < goal) begin
      case ($urandom_range(9))
        0, 1: begin
          send_ev(FUNC_PRESS, t_ms);
          t_ms += near_ms(short_ms);
          send_ev(FUNC_RELEASE, t_ms);
          t_ms += near_ms(win_ms);
          send_ev(FUNC_TICK, t_ms);
        end
        2, 3: begin
          send_ev(FUNC_PRESS, t_ms);
          t_ms += near_ms(short_ms);
          send_ev(FUNC_RELEASE, t_ms);
          t_ms += near_ms(win_ms);
          send_ev(FUNC_PRESS, t_ms);
          t_ms += near_ms(short_ms);
          send_ev(FUNC_RELEASE, t_ms);
        end
        4, 5: begin
          send_ev(FUNC_PRESS, t_ms);
          t_ms += near_ms(enter_ms);
          send_ev(FUNC_TICK, t_ms);
          if ($urandom_range(1)) begin
            t_ms += near_ms(enter_ms);
            send_ev(FUNC_TICK, t_ms);
          end
          t_ms += $urandom_range(200);
          send_ev(FUNC_RELEASE, t_ms);
          k = $urandom_range(3);
          repeat (k) begin
            t_ms += $urandom_range(60);
            send_ev(FUNC_PRESS, t_ms);
            t_ms += near_ms(short_ms);
            send_ev(FUNC_RELEASE, t_ms);
          end
          case ($urandom_range(2))
            0: begin
              t_ms += $urandom_range(60);
              send_ev(FUNC_PRESS, t_ms);
              t_ms += near_ms(confirm_hold_ms);
              send_ev(FUNC_TICK, t_ms);
              t_ms += near_ms(short_ms);
              send_ev(FUNC_RELEASE, t_ms);
            end
            1: begin
              t_ms += near_ms(timeout_ms);
              send_ev(FUNC_TICK, t_ms);
            end
            default: ;
          endcase
        end
        6: begin
          k = $urandom_range(1, 4);
          repeat (k) begin
            t_ms += $urandom_range(1000);
            send_ev(FUNC_TICK, t_ms);
          end
        end
        7: send_ev(2'($urandom_range(3)), $urandom);
        8: begin
          // large jump exercises wrap and the sign of the deadline distance
          t_ms += $urandom;
          send_ev(FUNC_TICK, t_ms);
        end
        default: begin
          send_ev(FUNC_PRESS, t_ms);
          t_ms += near_ms(short_ms);
          send_ev(FUNC_PRESS, t_ms);
          send_ev(FUNC_RELEASE, t_ms);
          t_ms += $urandom_range(100);
          send_ev(FUNC_RELEASE, t_ms);
        end
      endcase
    end
  endtask

  initial begin : rx_side
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    gesture_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      code_seen[event_res_o]++;
      if (gesture_q.size() == 0) begin
        report_mismatch("unexpected result transaction, event", event_res_o, 0);
      end else begin
        want = gesture_q.pop_front();
        if (event_res_o !== want.code) report_mismatch("event_res", event_res_o, want.code);
        if (mode_o !== want.mode) report_mismatch("mode", mode_o, want.mode);
      end
    end
  end

  initial begin : stimulus
    int ph;
    int i;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = '0;
    now_ms_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    for (i = 0; i < 8; i++) code_seen[i] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 27;
    snk_idle_pct = 70;
    for (i = 0; i < DirCount; i++)
      send_event(DirRows[i].fn, DirRows[i].now, DirRows[i].typed, DirRows[i].code,
                 DirRows[i].mode);
    drain_results();

    t_ms = $urandom;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CfgUnusedIdx, 16'hFFFF);
          apply_setting(16'd300, 16'd500, 16'd2000, 16'd1000, 16'd5000, 1'b1);
        end
        1: begin
          src_idle_pct = 70;
          snk_idle_pct = 27;
          apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        end
        2: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
          // receiver stalls while the sender keeps pushing, input must back up
          rx_hold_left = RxHoldCycles;
        end
        default: begin
          apply_setting(16'($urandom_range(1, 400)), 16'($urandom_range(1, 800)),
                        16'($urandom_range(1, 3000)), 16'($urandom_range(1, 2000)),
                        16'($urandom_range(1, 6000)), 1'($urandom_range(1)));
        end
      endcase
      run_gestures(DirCount + (ph + 1) * PhaseItems);
      drain_results();
    end

    $display("%0d events sent, %0d results checked across reset and four register settings",
             events_sent, results_seen);
    $display("singles %0d, menu opens %0d, moves %0d, timeouts %0d, confirms %0d/%0d",
             code_seen[EV_SINGLE], code_seen[EV_MENU_OPEN], code_seen[EV_MENU_MOVE],
             code_seen[EV_MENU_TIMEOUT], code_seen[EV_CONFIRM_SAME],
             code_seen[EV_CONFIRM_SWITCH]);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
